// ===== rtl/rma_pkg.sv =====
// Shared constants and types for the running and moving average unit.
// No dependencies; imported by rma_div and running_and_moving_average_unit.
package rma_pkg;

  // Sample and result field widths.
  localparam int unsigned SampleBits = 12;
  localparam int unsigned WeightBits = SampleBits + 8;

  // Sample counter and running total widths.
  localparam int unsigned CountBits  = 17;
  localparam int unsigned TotalBits  = 29;
  localparam logic [CountBits-1:0] MaxSamples = 17'd65535;
  localparam logic [CountBits-1:0] WinStart   = 17'd3;

  // Three-sample sum and weighted sum widths.
  localparam int unsigned SumBits  = SampleBits + 2;
  localparam int unsigned WsumBits = 30;

  // Shared divider: remainder/divisor width, quotient width, dividend low part.
  localparam int unsigned RemBits    = 18;
  localparam int unsigned QuoBits    = 20;
  localparam int unsigned LowBits    = 20;
  localparam int unsigned CmeanIters = 12;
  localparam int unsigned WeightIters = 20;
  localparam int unsigned IterBits   = 5;

  // Reciprocal of six for the rounded three-sample mean: x/6 = (x*Recip6) >> Recip6Shift.
  localparam logic [15:0] Recip6      = 16'd43691;
  localparam int unsigned Recip6Shift = 18;

  // Stream packing.
  localparam int unsigned InDataBits  = 16;
  localparam int unsigned OutDataBits = 48;
  localparam int unsigned OutUserBits = 2;

  // Divider command from the sequencer.
  typedef struct packed {
    logic load;
    logic step;
  } div_cmd_t;

endpackage

// ===== rtl/running_and_moving_average_unit.sv =====
// Running and moving average unit: top level with the sequencer and state.
// Depends on rma_pkg and instantiates the shared divider rma_div.
//
// Each input request carries one signed 12-bit sample and produces exactly one
// output request. The result holds the cumulative mean of all samples taken so
// far (truncated toward zero), the mean of the last three samples (rounded half
// away from zero) and an index-weighted three-sample mean in signed Q.8 fixed
// point (truncated toward zero). The window fields are zero and window_valid is
// low until the third sample. After 65535 samples every further request is
// answered with overflow set and zero fields, and the internal state is left
// unchanged. Both divisions run one after the other on a single restoring
// divider that produces one quotient bit per cycle, first for the cumulative
// mean and then for the weighted mean. A request passes through accept, setup,
// the cumulative-mean division, a handover, the weighted-mean division and the
// result step, which waits until the output register is free; the first two
// samples skip the weighted-mean division and overflow requests go from accept
// straight to the result step. The input is ready only while the unit is idle,
// and a finished result waits in an output register, so a new sample may be
// accepted while the previous result has not yet been taken.
module running_and_moving_average_unit import rma_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [InDataBits-1:0]  s_axis_tdata_i,   // [11:0] sample
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OutDataBits-1:0] m_axis_tdata_o,   // [11:0] cumulative_mean,
                                                   // [23:12] window_mean,
                                                   // [43:24] weighted_mean_q8
  output logic [OutUserBits-1:0] m_axis_tuser_o    // [0] window_valid, [1] overflow
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV_C,
    S_MID,
    S_DIV_W,
    S_DONE
  } state_e;

  state_e                     state_q;
  logic [IterBits-1:0]        iter_q;

  // Architectural state.
  logic signed [TotalBits-1:0]  total_q;
  logic [CountBits-1:0]         count_q;
  logic signed [SampleBits-1:0] prev0_q, prev1_q;

  // Per-request working registers.
  logic signed [SampleBits-1:0] smp_q;
  logic                         ovf_q;
  logic                         cneg_q;
  logic signed [WsumBits-1:0]   wsum_q;
  logic signed [SampleBits-1:0] cmean_q;
  logic signed [SampleBits-1:0] wmean_q;

  // Output register.
  logic                         out_valid_q;
  logic signed [SampleBits-1:0] out_cmean_q;
  logic signed [SampleBits-1:0] out_wmean_q;
  logic signed [WeightBits-1:0] out_wq8_q;
  logic                         out_win_q;
  logic                         out_ovf_q;

  logic                         in_fire;
  logic                         out_free;
  logic signed [SampleBits-1:0] sample_s;
  logic signed [TotalBits-1:0]  sample_ext;
  logic                         win_ok;

  logic [TotalBits-1:0]         tot_mag;
  logic [CountBits-1:0]         idx;
  logic signed [SumBits-1:0]    sum3;
  logic signed [CountBits+SumBits:0] prod;
  logic signed [SumBits-1:0]    diff_sa;
  logic signed [WsumBits-1:0]   wsum_c;
  logic [WsumBits-1:0]          wmag;
  logic [RemBits-1:0]           dsr_w;

  logic [SumBits-1:0]           smag;
  logic [SumBits:0]             rnd_x;
  logic [SumBits+16:0]          rnd_p;
  logic [SampleBits-1:0]        rnd_q;

  div_cmd_t                     div_cmd;
  logic [RemBits-1:0]           div_rem;
  logic [LowBits-1:0]           div_low;
  logic [RemBits-1:0]           div_dsr;
  logic [QuoBits-1:0]           div_quo;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = ~out_valid_q | m_axis_tready_i;
  assign sample_s        = signed'(s_axis_tdata_i[SampleBits-1:0]);
  assign sample_ext      = {{(TotalBits-SampleBits){sample_s[SampleBits-1]}}, sample_s};
  assign win_ok          = (count_q >= WinStart);

  // Operand preparation for both divisions and the rounded window mean.
  always_comb begin
    tot_mag = total_q[TotalBits-1] ? (TotalBits)'(-total_q) : total_q;
    idx     = count_q - 1'b1;
    sum3    = SumBits'(prev1_q) + SumBits'(prev0_q) + SumBits'(smp_q);
    diff_sa = SumBits'(smp_q) - SumBits'(prev1_q);
    // Weights i-1, i, i+1 collapse to i*(a+b+s) + (s-a).
    prod    = signed'({1'b0, idx}) * sum3;
    wsum_c  = WsumBits'(prod) + WsumBits'(diff_sa);
    wmag    = wsum_q[WsumBits-1] ? (WsumBits)'(-wsum_q) : wsum_q;
    dsr_w   = {idx, 1'b0} + RemBits'(idx);

    // Window mean: round(|sum|/3) = (2|sum|+3)/6, done with a reciprocal multiply.
    smag    = sum3[SumBits-1] ? (SumBits)'(-sum3) : sum3;
    rnd_x   = {smag, 1'b0} + (SumBits+1)'(3);
    rnd_p   = rnd_x * Recip6;
    rnd_q   = rnd_p[Recip6Shift +: SampleBits];
  end

  // Divider loads: the cumulative mean in the setup cycle, the weighted mean at handover once the window is valid.
  // Quotients are known to fit the iteration count, so the top dividend bits
  // start directly in the remainder.
  always_comb begin
    div_cmd = '0;
    div_rem = '0;
    div_low = '0;
    div_dsr = '0;
    unique case (state_q)
      S_PREP: begin
        div_cmd.load = 1'b1;
        div_rem = RemBits'(tot_mag[TotalBits-2:CmeanIters]);
        div_low = {tot_mag[CmeanIters-1:0], (LowBits-CmeanIters)'(0)};
        div_dsr = RemBits'(count_q);
      end
      S_MID: begin
        div_cmd.load = win_ok;
        div_rem = RemBits'(wmag[WsumBits-2:WeightIters-8]);
        div_low = {wmag[WeightIters-9:0], 8'h00};
        div_dsr = dsr_w;
      end
      S_DIV_C, S_DIV_W: begin
        div_cmd.step = 1'b1;
      end
      default: begin
        div_cmd = '0;
      end
    endcase
  end

  rma_div u_div (
    .clk_i (clk_i),
    .cmd_i (div_cmd),
    .rem_i (div_rem),
    .low_i (div_low),
    .dsr_i (div_dsr),
    .quo_o (div_quo)
  );

  // Sequencer, architectural state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      iter_q      <= '0;
      total_q     <= '0;
      count_q     <= '0;
      prev0_q     <= '0;
      prev1_q     <= '0;
      smp_q       <= '0;
      ovf_q       <= 1'b0;
      cneg_q      <= 1'b0;
      wsum_q      <= '0;
      cmean_q     <= '0;
      wmean_q     <= '0;
      out_valid_q <= 1'b0;
      out_cmean_q <= '0;
      out_wmean_q <= '0;
      out_wq8_q   <= '0;
      out_win_q   <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      // The output register is refilled when a result is ready and the slot is free.
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            smp_q <= sample_s;
            if (count_q >= MaxSamples) begin
              // The count limit is reached: answer with overflow and keep the state.
              ovf_q   <= 1'b1;
              state_q <= S_DONE;
            end else begin
              ovf_q   <= 1'b0;
              total_q <= total_q + sample_ext;
              count_q <= count_q + 1'b1;
              state_q <= S_PREP;
            end
          end
        end
        S_PREP: begin
          cneg_q  <= total_q[TotalBits-1];
          wsum_q  <= wsum_c;
          iter_q  <= '0;
          state_q <= S_DIV_C;
        end
        S_DIV_C: begin
          wmean_q <= sum3[SumBits-1] ? (SampleBits)'(-rnd_q) : rnd_q;
          iter_q  <= iter_q + 1'b1;
          if (iter_q == IterBits'(CmeanIters - 1)) begin
            state_q <= S_MID;
          end
        end
        S_MID: begin
          cmean_q <= cneg_q ? (SampleBits)'(-div_quo[SampleBits-1:0])
                            : div_quo[SampleBits-1:0];
          iter_q  <= '0;
          state_q <= win_ok ? S_DIV_W : S_DONE;
        end
        S_DIV_W: begin
          iter_q <= iter_q + 1'b1;
          if (iter_q == IterBits'(WeightIters - 1)) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_ovf_q <= ovf_q;
            if (ovf_q) begin
              out_cmean_q <= '0;
              out_wmean_q <= '0;
              out_wq8_q   <= '0;
              out_win_q   <= 1'b0;
            end else begin
              out_cmean_q <= cmean_q;
              out_win_q   <= win_ok;
              out_wmean_q <= win_ok ? wmean_q : '0;
              if (win_ok) begin
                out_wq8_q <= wsum_q[WsumBits-1] ? (WeightBits)'(-div_quo) : div_quo;
              end else begin
                out_wq8_q <= '0;
              end
              prev1_q <= prev0_q;
              prev0_q <= smp_q;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OutDataBits - 2*SampleBits - WeightBits)'(0),
                            out_wq8_q, out_wmean_q, out_cmean_q};
  assign m_axis_tuser_o  = {out_ovf_q, out_win_q};

endmodule

// ===== rtl/rma_div.sv =====
// Shared restoring divider, one quotient bit per cycle while the step command is held.
// Depends on rma_pkg for widths and the command struct.
module rma_div import rma_pkg::*; (
  input  logic               clk_i,
  input  div_cmd_t           cmd_i,
  input  logic [RemBits-1:0] rem_i,
  input  logic [LowBits-1:0] low_i,
  input  logic [RemBits-1:0] dsr_i,
  output logic [QuoBits-1:0] quo_o
);

  logic [RemBits-1:0] rem_q;
  logic [LowBits-1:0] low_q;
  logic [RemBits-1:0] dsr_q;
  logic [QuoBits-1:0] quo_q;
  logic [RemBits:0]   trial;
  logic [RemBits+1:0] diff;
  logic               fits;

  // The partial remainder always stays below the divisor, so one bit more holds the trial.
  always_comb begin
    trial = {rem_q, low_q[LowBits-1]};
    diff  = {1'b0, trial} - {2'b00, dsr_q};
    fits  = ~diff[RemBits+1];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q <= rem_i;
      low_q <= low_i;
      dsr_q <= dsr_i;
      quo_q <= '0;
    end else if (cmd_i.step) begin
      rem_q <= fits ? diff[RemBits-1:0] : trial[RemBits-1:0];
      low_q <= {low_q[LowBits-2:0], 1'b0};
      quo_q <= {quo_q[QuoBits-2:0], fits};
    end
  end

  assign quo_o = quo_q;

endmodule
